>>> rtl/vnh_pkg.sv
package vnh_pkg;

    localparam int COORD_W    = 32;
    localparam int HEIGHT_W   = 10;
    localparam int BASE_W     = 8;
    localparam int AMP_W      = 6;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_BASE_HEIGHT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE   = 2'd1;

    localparam logic [BASE_W-1:0] BASE_RESET = 8'd128;
    localparam logic [AMP_W-1:0]  AMP_RESET  = 6'd20;

    localparam int SPREAD_SHIFT_DEFAULT = 6;

    // register stages inside one corner hash unit
    localparam int HASH_STAGES = 6;

    localparam logic [31:0] HASH_MUL_X = 32'd93175;
    localparam logic [31:0] HASH_MUL_Z = 32'd777;
    localparam logic [30:0] HASH_A     = 31'd69313;
    localparam logic [30:0] HASH_B     = 31'd263167;
    localparam logic [30:0] HASH_C     = 31'd16785407;
    localparam logic [31:0] ONE_Q30    = 32'h4000_0000;

    typedef logic [COORD_W-1:0]        cell_t;
    typedef logic [30:0]               hash_t;
    typedef logic signed [31:0]        corner_t;

endpackage

>>> rtl/value_noise_height_2d_top.sv
// lattice value noise terrain height, one column (col_x, col_z) per request
//
// input channel: col_x, col_z with in_valid / in_stall; output channel:
// height with out_valid / out_stall. a request is taken on a rising edge
// with valid high and stall low.
// configuration: cfg_we writes cfg_data into register cfg_index
// (0 = base_height, 1 = amplitude, other indexes ignored); write only
// while no request is in flight.
// path: a request passes the split stage, the six stage corner hash
// (weights ride alongside), then the product, sum, scale and output
// stages, and then out_valid rises.
// throughput: one request per cycle while the output is not stalled, every stage holds one request.
// when the output holds a result and out_stall is high, the whole pipeline
// freezes and in_stall rises in the same cycle; nothing is dropped.
// reset clears every valid bit and loads base_height 128, amplitude 20.
module value_noise_height_2d_top
#(
    parameter int SPREAD_SHIFT = vnh_pkg::SPREAD_SHIFT_DEFAULT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [vnh_pkg::COORD_W-1:0]  col_x,
    input  logic signed [vnh_pkg::COORD_W-1:0]  col_z,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [vnh_pkg::HEIGHT_W-1:0] height,
    input  logic                                cfg_we,
    input  logic [vnh_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [vnh_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int K      = 30 + 2 * SPREAD_SHIFT;
    localparam int WW     = 2 * SPREAD_SHIFT + 1;
    localparam int PRW    = K + 2;
    localparam int NW     = K + 3;
    localparam int PW     = K + vnh_pkg::HEIGHT_W;
    localparam int NSTAGE = vnh_pkg::HASH_STAGES + 5;
    localparam int WDLY   = vnh_pkg::HASH_STAGES;

    logic                              adv;
    logic [NSTAGE-1:0]                 vld_reg;
    logic [NSTAGE-1:0]                 vld_next;

    logic [vnh_pkg::BASE_W-1:0]        base_height_reg;
    logic [vnh_pkg::AMP_W-1:0]         amplitude_reg;

    vnh_pkg::cell_t                    cell_x_reg;
    vnh_pkg::cell_t                    cell_z_reg;
    vnh_pkg::cell_t                    cell_x1_reg;
    vnh_pkg::cell_t                    cell_z1_reg;
    logic [SPREAD_SHIFT-1:0]           frac_x_reg;
    logic [SPREAD_SHIFT-1:0]           frac_z_reg;

    logic [SPREAD_SHIFT:0]             wx0;
    logic [SPREAD_SHIFT:0]             wx1;
    logic [SPREAD_SHIFT:0]             wz0;
    logic [SPREAD_SHIFT:0]             wz1;
    logic [WW-1:0]                     wgt_next [4];
    logic [WW-1:0]                     wgt_reg  [WDLY][4];

    vnh_pkg::corner_t                  corner   [4];
    logic signed [PRW-1:0]             prod_reg [4];
    logic signed [NW-1:0]              sum_next;
    logic signed [NW-1:0]              sum_reg;
    logic signed [PW-1:0]              amp_ext;
    logic signed [PW-1:0]              base_ext;
    logic signed [PW-1:0]              sum_ext;
    logic signed [PW-1:0]              scaled_next;
    logic signed [PW-1:0]              scaled_reg;
    logic [vnh_pkg::HEIGHT_W-1:0]      height_next;
    logic [vnh_pkg::HEIGHT_W-1:0]      height_reg;

    // everything moves together unless the output holds a stalled result
    assign adv       = !(vld_reg[NSTAGE-1] && out_stall);
    assign in_stall  = !adv;
    assign out_valid = vld_reg[NSTAGE-1];
    assign height    = signed'(height_reg);
    assign vld_next  = {vld_reg[NSTAGE-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_height_reg <= vnh_pkg::BASE_RESET;
            amplitude_reg   <= vnh_pkg::AMP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                vnh_pkg::REG_BASE_HEIGHT: base_height_reg <= cfg_data[vnh_pkg::BASE_W-1:0];
                vnh_pkg::REG_AMPLITUDE:   amplitude_reg   <= cfg_data[vnh_pkg::AMP_W-1:0];
                default:                  ;
            endcase
        end
    end

    // cell is the floor of the coordinate over the cell size
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cell_x_reg  <= col_x >>> SPREAD_SHIFT;
            cell_z_reg  <= col_z >>> SPREAD_SHIFT;
            cell_x1_reg <= (col_x >>> SPREAD_SHIFT) + 32'sd1;
            cell_z1_reg <= (col_z >>> SPREAD_SHIFT) + 32'sd1;
            frac_x_reg  <= col_x[SPREAD_SHIFT-1:0];
            frac_z_reg  <= col_z[SPREAD_SHIFT-1:0];
        end
    end

    always_comb
    begin
        wx1 = {1'b0, frac_x_reg};
        wz1 = {1'b0, frac_z_reg};
        wx0 = {1'b1, {SPREAD_SHIFT{1'b0}}} - wx1;
        wz0 = {1'b1, {SPREAD_SHIFT{1'b0}}} - wz1;
        wgt_next[0] = WW'(wx0) * WW'(wz0);
        wgt_next[1] = WW'(wx1) * WW'(wz0);
        wgt_next[2] = WW'(wx0) * WW'(wz1);
        wgt_next[3] = WW'(wx1) * WW'(wz1);
    end

    // weights ride alongside the hash units
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wgt_reg[0] <= wgt_next;
            for (int j = 1; j < WDLY; j++)
            begin
                wgt_reg[j] <= wgt_reg[j-1];
            end
        end
    end

    // corner order: (x, z), (x+1, z), (x, z+1), (x+1, z+1)
    for (genvar c = 0; c < 4; c++)
    begin : g_corner
        vnh_hash u_hash
        (
            .clk    (clk),
            .en     (adv),
            .cell_x ((c % 2 == 1) ? cell_x1_reg : cell_x_reg),
            .cell_z ((c / 2 == 1) ? cell_z1_reg : cell_z_reg),
            .value  (corner[c])
        );
    end

    always_comb
    begin
        sum_next = NW'(prod_reg[0]) + NW'(prod_reg[1])
                 + NW'(prod_reg[2]) + NW'(prod_reg[3]);
        amp_ext  = PW'(signed'({1'b0, amplitude_reg}));
        base_ext = signed'(PW'({base_height_reg, {K{1'b0}}}));
        sum_ext  = PW'(sum_reg);
        scaled_next = amp_ext * sum_ext + base_ext;
        // floor shift, then step toward zero when negative with a remainder
        height_next = scaled_reg[PW-1:K];
        if (scaled_reg[PW-1] && (|scaled_reg[K-1:0]))
        begin
            height_next = scaled_reg[PW-1:K] + {{(vnh_pkg::HEIGHT_W-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
            begin
                prod_reg[i] <= PRW'(PRW'(corner[i]) * signed'(PRW'(wgt_reg[WDLY-1][i])));
            end
            sum_reg    <= sum_next;
            scaled_reg <= scaled_next;
            height_reg <= height_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && vld_reg[0]) |=> vld_reg[1])
        else $error("request lost between first and second stage");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved while output stalled");

    a_corner_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[vnh_pkg::HASH_STAGES] |->
            (corner[0] <= 32'sd1073741824 && corner[0] > -32'sd1073741824))
        else $error("corner value out of range");

    a_height_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (height >= -10'sd64 && height <= 10'sd320))
        else $error("height out of range");
`endif

endmodule

>>> rtl/vnh_hash.sv
module vnh_hash
(
    input  logic              clk,
    input  logic              en,
    input  vnh_pkg::cell_t    cell_x,
    input  vnh_pkg::cell_t    cell_z,
    output vnh_pkg::corner_t  value
);

    logic [31:0]       px_reg;
    logic [31:0]       pz_reg;
    logic [31:0]       sum_next;
    logic [31:0]       mix_next;
    vnh_pkg::hash_t    mix_reg;
    vnh_pkg::hash_t    sq_reg;
    vnh_pkg::hash_t    mix_d3_reg;
    vnh_pkg::hash_t    poly_reg;
    vnh_pkg::hash_t    mix_d4_reg;
    vnh_pkg::hash_t    hv_reg;
    vnh_pkg::corner_t  value_reg;

    always_comb
    begin
        sum_next = px_reg + pz_reg;
        // arithmetic shift right by 13, folded back in
        mix_next = {{13{sum_next[31]}}, sum_next[31:13]} ^ sum_next;
    end

    // only the low 31 bits of the polynomial survive the final mask
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg     <= vnh_pkg::HASH_MUL_X * cell_x;
            pz_reg     <= vnh_pkg::HASH_MUL_Z * cell_z;
            mix_reg    <= mix_next[30:0];
            sq_reg     <= mix_reg * mix_reg;
            mix_d3_reg <= mix_reg;
            poly_reg   <= sq_reg * vnh_pkg::HASH_A + vnh_pkg::HASH_B;
            mix_d4_reg <= mix_d3_reg;
            hv_reg     <= mix_d4_reg * poly_reg + vnh_pkg::HASH_C;
            value_reg  <= signed'(vnh_pkg::ONE_Q30 - {1'b0, hv_reg});
        end
    end

    assign value = value_reg;

endmodule
